// ===== rtl/eism_pkg.sv =====
// ----------------------------------------------------------------------------
// eism_pkg: shared definitions of the encoder index slip monitor
// Field widths, register indexes, reset values and the control and status
// bundles between the sequencer and the serial remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package eism_pkg;

  localparam int TickW   = 32;
  localparam int PosW    = 32;
  localparam int CountW  = 32;
  localparam int ErrW    = 16;
  localparam int CprW    = 16;
  localparam int ThrW    = 15;
  localparam int IntW    = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 16;
  // Remainder magnitude stays below 2 * modulus during a step.
  localparam int RemW    = CprW + 1;
  // Signed remainder and fold arithmetic.
  localparam int FoldW   = CprW + 2;
  localparam int StepW   = $clog2(PosW);

  localparam logic [CfgIdxW-1:0] CfgCountsPerRev = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSlipThresh   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinInterval  = 2'd2;

  localparam logic [CprW-1:0] CprReset = 16'd4800;
  localparam logic [ThrW-1:0] ThrReset = 15'd48;
  localparam logic [IntW-1:0] IntReset = 16'd5;

  localparam logic CmdPulse = 1'b0;
  localparam logic CmdClear = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/eism_in_if.sv =====
// ----------------------------------------------------------------------------
// eism_in_if: input item channel
// Carries an index pulse event or a clear command with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface eism_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [eism_pkg::TickW-1:0]       now_ms;
  logic signed [eism_pkg::PosW-1:0] position;

  modport source (output valid, command, now_ms, position, input ready);
  modport sink   (input valid, command, now_ms, position, output ready);
endinterface

`default_nettype wire

// ===== rtl/eism_out_if.sv =====
// ----------------------------------------------------------------------------
// eism_out_if: result item channel
// Carries the monitor state after each item with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface eism_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic [eism_pkg::CountW-1:0]       pulse_count;
  logic signed [eism_pkg::PosW-1:0]  last_position;
  logic signed [eism_pkg::ErrW-1:0]  last_error;
  logic                              slip;

  modport source (output valid, accepted, pulse_count, last_position, last_error, slip,
                  input ready);
  modport sink   (input valid, accepted, pulse_count, last_position, last_error, slip,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/eism_cfg_if.sv =====
// ----------------------------------------------------------------------------
// eism_cfg_if: configuration write channel
// Carries a register index and write data with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface eism_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [eism_pkg::CfgIdxW-1:0] index;
  logic [eism_pkg::CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/eism_div.sv =====
// ----------------------------------------------------------------------------
// eism_div: serial truncating remainder unit
// Restoring division, one dividend bit a cycle; the remainder takes the sign
// of the dividend, as a truncating remainder does.
// ----------------------------------------------------------------------------
`default_nettype none

module eism_div (
  input  wire                                clk,
  input  wire                                rst_n,
  input  eism_pkg::div_ctrl_t                ctrl,
  input  wire signed [eism_pkg::PosW-1:0]    dividend,
  input  wire [eism_pkg::CprW-1:0]           divisor,
  output eism_pkg::div_stat_t                stat,
  output logic signed [eism_pkg::FoldW-1:0]  rem
);

  logic [eism_pkg::PosW-1:0]  mag_r, mag_nxt;
  logic [eism_pkg::RemW-1:0]  rem_r, rem_nxt;
  logic [eism_pkg::StepW-1:0] step_r, step_nxt;
  logic                       neg_r, neg_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [eism_pkg::RemW-1:0]  shifted;
  logic [eism_pkg::RemW-1:0]  div_ext;
  logic signed [eism_pkg::FoldW-1:0] rem_pos;

  assign shifted = {rem_r[eism_pkg::RemW-2:0], mag_r[eism_pkg::PosW-1]};
  assign div_ext = {1'b0, divisor};

  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      neg_nxt  = dividend[eism_pkg::PosW-1];
      mag_nxt  = dividend[eism_pkg::PosW-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = (shifted >= div_ext) ? (shifted - div_ext) : shifted;
      mag_nxt  = {mag_r[eism_pkg::PosW-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == eism_pkg::StepW'(eism_pkg::PosW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign rem_pos   = $signed({1'b0, rem_r});
  assign rem       = neg_r ? -rem_pos : rem_pos;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ===== rtl/encoder_index_slip_monitor.sv =====
// ----------------------------------------------------------------------------
// encoder_index_slip_monitor: index pulse debounce and slip detection
// Debounces index pulses of a quadrature encoder, checks the count delta
// between accepted pulses against whole revolutions and latches slip.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload                                        | Transfer
//   in_ch   | sink      | command, now_ms, position                      | valid & ready
//   out_ch  | source    | accepted, pulse_count, last_position,          | valid & ready
//           |           | last_error, slip                               |
//   cfg_ch  | sink      | index, data                                    | valid & ready
//
// A clear command, a rejected pulse or the first accepted pulse goes from the idle
// state through the check state to the done state; a checked pulse also passes the
// delta state, the divide state with the unit's 32 one-bit steps and the fold state.
// Reset (synchronous, active low) clears all monitor state and loads the
// register defaults; no clearing pass is needed. in_ch.ready is high only while
// the sequencer is idle. A result waits in the output register until taken,
// and the next input item may be transferred meanwhile; a later result stalls
// the sequencer only while the output register is still full. Configuration
// transfers are taken in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_index_slip_monitor (
  input wire         clk,
  input wire         rst_n,
  eism_in_if.sink    in_ch,
  eism_out_if.source out_ch,
  eism_cfg_if.sink   cfg_ch
);

  // Sequencer codes.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDelta = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StFold  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Configuration registers.
  logic [eism_pkg::CprW-1:0] cpr_r;
  logic [eism_pkg::ThrW-1:0] thr_r;
  logic [eism_pkg::IntW-1:0] int_r;

  // Monitor state.
  logic [eism_pkg::TickW-1:0]       tick_r, tick_nxt;
  logic signed [eism_pkg::PosW-1:0] spos_r, spos_nxt;
  logic [eism_pkg::CountW-1:0]      count_r, count_nxt;
  logic signed [eism_pkg::ErrW-1:0] err_r, err_nxt;
  logic                             slip_r, slip_nxt;

  // Captured item and working values.
  logic                             cmd_r;
  logic [eism_pkg::TickW-1:0]       now_r;
  logic signed [eism_pkg::PosW-1:0] pos_r;
  logic                             acc_r, acc_nxt;
  logic signed [eism_pkg::PosW-1:0] delta_r, delta_nxt;

  // Output register.
  logic                              out_valid_r;
  logic                              o_acc_r;
  logic [eism_pkg::CountW-1:0]       o_count_r;
  logic signed [eism_pkg::PosW-1:0]  o_pos_r;
  logic signed [eism_pkg::ErrW-1:0]  o_err_r;
  logic                              o_slip_r;

  logic                 in_xfer;
  logic                 out_load;
  logic [eism_pkg::TickW-1:0] elapsed;

  eism_pkg::div_ctrl_t               div_ctrl;
  eism_pkg::div_stat_t               div_stat;
  logic signed [eism_pkg::FoldW-1:0] rem;

  // Fold of the remainder into plus or minus half a revolution.
  logic signed [eism_pkg::FoldW-1:0] modulus;
  logic signed [eism_pkg::FoldW-1:0] half;
  logic signed [eism_pkg::FoldW-1:0] folded;
  logic signed [eism_pkg::FoldW-1:0] err_abs;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == StDone) && (!out_valid_r || out_ch.ready);
  assign elapsed  = now_r - tick_r;

  assign modulus = $signed({2'b00, cpr_r});
  assign half    = modulus >>> 1;

  always_comb begin
    if (cpr_r == '0) begin
      // A zero modulus counts as a remainder of zero.
      folded = '0;
    end else if (rem > half) begin
      folded = rem - modulus;
    end else if (rem < -half) begin
      folded = rem + modulus;
    end else begin
      folded = rem;
    end
    err_abs = folded[eism_pkg::FoldW-1] ? -folded : folded;
  end

  always_comb begin
    state_nxt    = state_r;
    tick_nxt     = tick_r;
    spos_nxt     = spos_r;
    count_nxt    = count_r;
    err_nxt      = err_r;
    slip_nxt     = slip_r;
    acc_nxt      = acc_r;
    delta_nxt    = delta_r;
    div_ctrl.start = 1'b0;
    case (state_r)
      StIdle: begin
        if (in_xfer) begin
          state_nxt = StCheck;
        end
      end
      StCheck: begin
        acc_nxt   = 1'b0;
        state_nxt = StDone;
        if (cmd_r == eism_pkg::CmdClear) begin
          slip_nxt = 1'b0;
        end else if (elapsed >= eism_pkg::TickW'(int_r)) begin
          acc_nxt  = 1'b1;
          tick_nxt = now_r;
          if (count_r == '0) begin
            // The first accepted pulse only records its position and is counted; it is not checked.
            spos_nxt  = pos_r;
            count_nxt = count_r + 1'b1;
          end else begin
            state_nxt = StDelta;
          end
        end
      end
      StDelta: begin
        delta_nxt = pos_r - spos_r;
        state_nxt = StDiv;
      end
      StDiv: begin
        // Start is issued on entry; the unit reports done after 32 steps.
        if (!div_stat.busy && !div_stat.done) begin
          div_ctrl.start = 1'b1;
        end
        if (div_stat.done) begin
          state_nxt = StFold;
        end
      end
      StFold: begin
        err_nxt   = folded[eism_pkg::ErrW-1:0];
        if (err_abs > $signed({3'b000, thr_r})) begin
          slip_nxt = 1'b1;
        end
        spos_nxt  = pos_r;
        count_nxt = count_r + 1'b1;
        state_nxt = StDone;
      end
      StDone: begin
        if (out_load) begin
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  eism_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (delta_r),
    .divisor  (cpr_r),
    .stat     (div_stat),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      cpr_r       <= eism_pkg::CprReset;
      thr_r       <= eism_pkg::ThrReset;
      int_r       <= eism_pkg::IntReset;
      tick_r      <= '0;
      spos_r      <= '0;
      count_r     <= '0;
      err_r       <= '0;
      slip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      spos_r  <= spos_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
      slip_r  <= slip_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          eism_pkg::CfgCountsPerRev: cpr_r <= cfg_ch.data;
          eism_pkg::CfgSlipThresh:   thr_r <= cfg_ch.data[eism_pkg::ThrW-1:0];
          eism_pkg::CfgMinInterval:  int_r <= cfg_ch.data;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    acc_r   <= acc_nxt;
    delta_r <= delta_nxt;
    if (in_xfer) begin
      cmd_r <= in_ch.command;
      now_r <= in_ch.now_ms;
      pos_r <= in_ch.position;
    end
    if (out_load) begin
      // The result shows the state after the item.
      o_acc_r   <= acc_r;
      o_count_r <= count_r;
      o_pos_r   <= spos_r;
      o_err_r   <= err_r;
      o_slip_r  <= slip_r;
    end
  end

  assign in_ch.ready          = (state_r == StIdle);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.accepted      = o_acc_r;
  assign out_ch.pulse_count   = o_count_r;
  assign out_ch.last_position = o_pos_r;
  assign out_ch.last_error    = o_err_r;
  assign out_ch.slip          = o_slip_r;

endmodule

`default_nettype wire

// ===== test/encoder_index_slip_monitor_tb.sv =====
// ----------------------------------------------------------------------------
// encoder_index_slip_monitor_tb: self-checking bench of the index slip monitor
// Drives index pulses and clear commands through the input channel, rewrites
// the three registers between phases and checks every result transfer against
// a cycle-free model of debounce, modular delta folding and the slip latch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module encoder_index_slip_monitor_tb;

  // Register index that maps to no register; a write to it must change nothing.
  localparam logic [eism_pkg::CfgIdxW-1:0] CfgUnmapped = 2'd3;

  localparam int NumDirected    = 33;
  localparam int RandomPerPhase = 250;
  localparam int SettleCycles   = 4;
  // This leaves room for the slowest item, a checked pulse, after the drain.
  localparam int TailCycles     = 60;
  localparam int CycleLimit     = 400000;
  localparam int MaxPrinted     = 40;

  // One result item, in the order of the output channel's payload.
  typedef struct packed {
    logic                             accepted;
    logic [eism_pkg::CountW-1:0]      pulse_count;
    logic signed [eism_pkg::PosW-1:0] last_position;
    logic signed [eism_pkg::ErrW-1:0] last_error;
    logic                             slip;
  } monitor_status_t;

  typedef enum logic [1:0] {RowPulse, RowClear, RowWrite} row_kind_t;

  // A pulse row carries now_ms in arg_a and position in arg_b. A write row
  // carries the register index in arg_a and the write data in arg_b. When
  // typed is set, the expected result is the one written in the row.
  typedef struct packed {
    row_kind_t       kind;
    logic [31:0]     arg_a;
    logic [31:0]     arg_b;
    logic            typed;
    monitor_status_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  eism_in_if  in_ch ();
  eism_out_if out_ch ();
  eism_cfg_if cfg_ch ();

  encoder_index_slip_monitor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model copy of the registers.
  logic [eism_pkg::CprW-1:0] cpr_reg;
  logic [eism_pkg::ThrW-1:0] thr_reg;
  logic [eism_pkg::IntW-1:0] min_gap_reg;

  // Model copy of the monitor state.
  logic [eism_pkg::TickW-1:0]       seen_tick;
  logic [eism_pkg::PosW-1:0]        seen_position;
  logic [eism_pkg::CountW-1:0]      seen_count;
  logic signed [eism_pkg::ErrW-1:0] seen_error;
  logic                             seen_slip;

  monitor_status_t pending_status[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  stim_row_t directed_rows [NumDirected];

  // Applies one accepted input item to the model state and returns the result
  // that the block must show afterwards.
  function automatic monitor_status_t advance_monitor(
      input logic cmd,
      input logic [eism_pkg::TickW-1:0] now_ms,
      input logic [eism_pkg::PosW-1:0] position);
    monitor_status_t st;
    logic [eism_pkg::TickW-1:0] elapsed;
    logic signed [eism_pkg::PosW-1:0] diff;
    longint delta;
    longint modulus;
    longint rem;
    longint threshold;
    st = '0;
    if (cmd == eism_pkg::CmdClear) begin
      seen_slip = 1'b0;
    end else begin
      // Elapsed time wraps modulo 2^32 and compares unsigned.
      elapsed = now_ms - seen_tick;
      if (elapsed >= {16'h0000, min_gap_reg}) begin
        seen_tick   = now_ms;
        st.accepted = 1'b1;
        // The first accepted pulse has nothing to compare against.
        if (seen_count != '0) begin
          diff      = position - seen_position;
          delta     = longint'(diff);
          modulus   = longint'(cpr_reg);
          threshold = longint'(thr_reg);
          rem       = 0;
          // A zero modulus leaves the remainder at zero.
          if (modulus != 0) begin
            rem = delta % modulus;
            if (rem > modulus / 2) rem = rem - modulus;
            if (rem < -(modulus / 2)) rem = rem + modulus;
          end
          seen_error = rem[eism_pkg::ErrW-1:0];
          if (rem < 0) rem = -rem;
          if (rem > threshold) seen_slip = 1'b1;
        end
        seen_position = position;
        seen_count    = seen_count + 1'b1;
      end
    end
    st.pulse_count   = seen_count;
    st.last_position = seen_position;
    st.last_error    = seen_error;
    st.slip          = seen_slip;
    return st;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MaxPrinted) begin
      $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  // Result side. The ready decision for the next cycle is made at every edge,
  // and the transfer is judged on the values that held before the edge.
  always @(posedge clk) begin : result_check
    monitor_status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result with nothing pending", 32'h0, 32'h0);
      end else begin
        want = pending_status.pop_front();
        if (out_ch.accepted !== want.accepted)
          report_mismatch("accepted", 32'(out_ch.accepted), 32'(want.accepted));
        if (out_ch.pulse_count !== want.pulse_count)
          report_mismatch("pulse_count", out_ch.pulse_count, want.pulse_count);
        if (out_ch.last_position !== want.last_position)
          report_mismatch("last_position", out_ch.last_position, want.last_position);
        if (out_ch.last_error !== want.last_error)
          report_mismatch("last_error", 32'(out_ch.last_error), 32'(want.last_error));
        if (out_ch.slip !== want.slip)
          report_mismatch("slip", 32'(out_ch.slip), 32'(want.slip));
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sends one item, with an optional idle gap before it, and records what the
  // block has to answer once the transfer has happened. A typed row overrides
  // the model's answer, while the model still follows the state.
  task automatic transfer_item(input logic cmd, input logic [eism_pkg::TickW-1:0] now_ms,
                               input logic [eism_pkg::PosW-1:0] position,
                               input logic typed, input monitor_status_t fixed);
    monitor_status_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.now_ms   <= now_ms;
    in_ch.position <= position;
    do @(posedge clk); while (!in_ch.ready);
    predicted = advance_monitor(cmd, now_ms, position);
    pending_status.push_back(typed ? fixed : predicted);
  endtask

  // Holds the sender off until every pending result has been taken.
  task automatic wait_for_drain(input int settle);
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [eism_pkg::CfgIdxW-1:0] index,
                                input logic [eism_pkg::CfgDatW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    // Unused bits of the threshold register are dropped.
    case (index)
      eism_pkg::CfgCountsPerRev: cpr_reg = data;
      eism_pkg::CfgSlipThresh:   thr_reg = data[eism_pkg::ThrW-1:0];
      eism_pkg::CfgMinInterval:  min_gap_reg = data;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random item. Most are pulses at least one debounce window after the last
  // accepted one, at whole turns plus a jitter, often near the threshold; the
  // rest are clears, pure noise and early pulses, rejected if a window is set.
  task automatic random_item();
    int pick;
    int unsigned turns;
    logic cmd_v;
    logic [eism_pkg::TickW-1:0] now_v;
    logic [eism_pkg::PosW-1:0] pos_v;
    logic [31:0] jitter;
    logic [31:0] span;
    pick  = $urandom_range(99);
    cmd_v = eism_pkg::CmdPulse;
    now_v = $urandom;
    pos_v = $urandom;
    if (pick < 8) begin
      cmd_v = eism_pkg::CmdClear;
    end else if (pick < 16) begin
      // Noise: now_ms and position stay fully random.
    end else if (pick < 26) begin
      if (min_gap_reg != '0) now_v = seen_tick + $urandom_range(min_gap_reg - 1);
      else now_v = seen_tick + $urandom_range(3);
    end else begin
      now_v = seen_tick + min_gap_reg + $urandom_range(5);
      turns = $urandom_range(3);
      case ($urandom_range(3))
        0: jitter = '0;
        1: begin
          span   = thr_reg + 2;
          jitter = $urandom_range(2 * span) - span;
        end
        2: jitter = $urandom_range(cpr_reg) - (cpr_reg >> 1);
        default: jitter = $urandom_range(7) - 3;
      endcase
      if ($urandom_range(1) != 0) pos_v = seen_position + turns * cpr_reg + jitter;
      else pos_v = seen_position - turns * cpr_reg + jitter;
    end
    transfer_item(cmd_v, now_v, pos_v, 1'b0, '0);
  endtask

  initial begin : stimulus
    stim_row_t row;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= eism_pkg::CmdPulse;
    in_ch.now_ms   <= '0;
    in_ch.position <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= eism_pkg::CfgCountsPerRev;
    cfg_ch.data    <= '0;
    rst_n          <= 1'b0;

    cpr_reg       = eism_pkg::CprReset;
    thr_reg       = eism_pkg::ThrReset;
    min_gap_reg   = eism_pkg::IntReset;
    seen_tick     = '0;
    seen_position = '0;
    seen_count    = '0;
    seen_error    = '0;
    seen_slip     = 1'b0;

    // Directed table. The first rows run on the reset registers: modulus
    // 4800, threshold 48 and a 5 ms window.
    directed_rows = '{
      // Early pulses after reset fall inside the window from tick 0.
      '{RowPulse, 32'd0, 32'd123, 1'b1, '{1'b0, 32'd0, 32'sd0, 16'sd0, 1'b0}},
      '{RowPulse, 32'd4, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, 32'sd0, 16'sd0, 1'b0}},
      '{RowClear, 32'd0, 32'd0, 1'b1, '{1'b0, 32'd0, 32'sd0, 16'sd0, 1'b0}},
      // First accepted pulse: stored, but not checked.
      '{RowPulse, 32'd5, 32'd1000, 1'b1, '{1'b1, 32'd1, 32'sd1000, 16'sd0, 1'b0}},
      '{RowPulse, 32'd9, 32'd5800, 1'b1, '{1'b0, 32'd1, 32'sd1000, 16'sd0, 1'b0}},
      // A whole turn, then a deviation right at the threshold, then one past it.
      '{RowPulse, 32'd10, 32'd5800, 1'b1, '{1'b1, 32'd2, 32'sd5800, 16'sd0, 1'b0}},
      '{RowPulse, 32'd20, 32'd10648, 1'b1, '{1'b1, 32'd3, 32'sd10648, 16'sd48, 1'b0}},
      '{RowPulse, 32'd30, 32'd15399, 1'b1, '{1'b1, 32'd4, 32'sd15399, -16'sd49, 1'b1}},
      '{RowClear, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
        '{1'b0, 32'd4, 32'sd15399, -16'sd49, 1'b0}},
      // Timestamps and positions at the extremes, with the tick wrapping.
      '{RowPulse, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
      '{RowPulse, 32'd3, 32'd0, 1'b0, '0},
      '{RowPulse, 32'd4, 32'h8000_0000, 1'b0, '0},
      // Zero modulus, all-ones threshold data, zero window, unmapped index.
      '{RowWrite, 32'(eism_pkg::CfgCountsPerRev), 32'h0000, 1'b0, '0},
      '{RowWrite, 32'(eism_pkg::CfgSlipThresh), 32'hFFFF, 1'b0, '0},
      '{RowWrite, 32'(eism_pkg::CfgMinInterval), 32'h0000, 1'b0, '0},
      '{RowWrite, 32'(CfgUnmapped), 32'hFFFF, 1'b0, '0},
      '{RowPulse, 32'd4, 32'd12345, 1'b0, '0},
      '{RowClear, 32'd0, 32'd0, 1'b0, '0},
      // Largest modulus and window, zero threshold.
      '{RowWrite, 32'(eism_pkg::CfgCountsPerRev), 32'hFFFF, 1'b0, '0},
      '{RowWrite, 32'(eism_pkg::CfgSlipThresh), 32'h0000, 1'b0, '0},
      '{RowWrite, 32'(eism_pkg::CfgMinInterval), 32'hFFFF, 1'b0, '0},
      '{RowPulse, 32'd65538, 32'd5, 1'b0, '0},
      '{RowPulse, 32'd65539, 32'h8000_0000, 1'b0, '0},
      '{RowPulse, 32'd196609, 32'h7FFF_FFFF, 1'b0, '0},
      // A modulus of one always leaves remainder zero.
      '{RowWrite, 32'(eism_pkg::CfgCountsPerRev), 32'h0001, 1'b0, '0},
      '{RowWrite, 32'(eism_pkg::CfgMinInterval), 32'h0005, 1'b0, '0},
      '{RowPulse, 32'd300000, 32'd1234567, 1'b0, '0},
      '{RowClear, 32'd0, 32'd0, 1'b0, '0},
      // Smallest sensible modulus, both signs of the fold.
      '{RowWrite, 32'(eism_pkg::CfgCountsPerRev), 32'h0002, 1'b0, '0},
      '{RowWrite, 32'(eism_pkg::CfgSlipThresh), 32'h0000, 1'b0, '0},
      '{RowPulse, 32'd300010, 32'd1234568, 1'b0, '0},
      '{RowPulse, 32'd300020, 32'd1234565, 1'b0, '0},
      '{RowClear, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        RowWrite: begin
          wait_for_drain(SettleCycles);
          write_register(row.arg_a[eism_pkg::CfgIdxW-1:0],
                         row.arg_b[eism_pkg::CfgDatW-1:0]);
        end
        RowClear: transfer_item(eism_pkg::CmdClear, row.arg_a, row.arg_b, row.typed,
                                row.want);
        default:  transfer_item(eism_pkg::CmdPulse, row.arg_a, row.arg_b, row.typed,
                                row.want);
      endcase
    end

    // Random phases. Each starts from a drained block, so the register writes
    // land while it is idle and the sender has paused for every result.
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_drain(SettleCycles);
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          write_register(eism_pkg::CfgCountsPerRev, eism_pkg::CprReset);
          write_register(eism_pkg::CfgSlipThresh, 16'(eism_pkg::ThrReset));
          write_register(eism_pkg::CfgMinInterval, eism_pkg::IntReset);
        end
        1: begin
          send_idle_pct = 48;
          stall_pct     = 0;
          write_register(eism_pkg::CfgCountsPerRev, 16'd2);
          write_register(eism_pkg::CfgSlipThresh, 16'd0);
          write_register(eism_pkg::CfgMinInterval, 16'd0);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 48;
          write_register(eism_pkg::CfgCountsPerRev, 16'd65534);
          write_register(eism_pkg::CfgSlipThresh, 16'd32767);
          write_register(eism_pkg::CfgMinInterval, 16'd65535);
        end
        default: begin
          send_idle_pct = 20;
          stall_pct     = 20;
          write_register(eism_pkg::CfgCountsPerRev, 16'($urandom_range(2, 65534)));
          write_register(eism_pkg::CfgSlipThresh, 16'($urandom_range(300)));
          write_register(eism_pkg::CfgMinInterval, 16'($urandom_range(20)));
        end
      endcase
      repeat (RandomPerPhase) random_item();
    end

    // Drain, then watch a little longer for any result nobody asked for.
    wait_for_drain(TailCycles);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
